[hw/rtl/tcc_pkg.sv]
// shared types, constants and helpers for the translational cue channel
package tcc_pkg;

    localparam int TAPS_DEFAULT = 64;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME  = 2'd2;

    localparam int FIR_FRAC_SHIFT   = 28;
    localparam int SCALE_FRAC_SHIFT = 16;
    localparam int INTEG_SHIFT      = 17;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FILT,
        ST_SC_MUL,
        ST_SC_RES,
        ST_V_MUL,
        ST_V_RES,
        ST_P_MUL,
        ST_P_RES,
        ST_COMMIT
    } tcc_state_t;

    typedef enum logic [1:0] {
        MUL_MAC,
        MUL_SCALE,
        MUL_VEL,
        MUL_POS
    } tcc_mul_sel_t;

    typedef struct packed {
        logic         clear_wr;
        logic         accept_load;
        logic         accept_sample;
        logic         mac_issue;
        tcc_mul_sel_t mul_sel;
        logic         filt_ld;
        logic         scaled_ld;
        logic         vel_ld;
        logic         pos_ld;
        logic         commit;
    } tcc_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic mac_last;
        logic pipe_busy;
    } tcc_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/tcc_ram.sv]
// generic simple dual-port ram with registered read
module tcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/tcc_ctrl.sv]
// sequencer for clearing, tap loads and the per-sample filter steps
module tcc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_action,
    output logic                s_ready,
    input  logic                m_ready,
    output logic                m_valid,
    input  tcc_pkg::tcc_status_t status,
    output tcc_pkg::tcc_cmd_t   cmd
);
    import tcc_pkg::*;

    tcc_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_MAC;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_action) begin
                        cmd.accept_sample = 1'b1;
                        state_next        = ST_MAC;
                    end else begin
                        cmd.accept_load = 1'b1;
                    end
                end
            end
            ST_MAC: begin
                cmd.mac_issue = 1'b1;
                if (status.mac_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_FILT;
                end
            end
            ST_FILT: begin
                cmd.filt_ld = 1'b1;
                state_next  = ST_SC_MUL;
            end
            ST_SC_MUL: begin
                cmd.mul_sel = MUL_SCALE;
                state_next  = ST_SC_RES;
            end
            ST_SC_RES: begin
                cmd.scaled_ld = 1'b1;
                state_next    = ST_V_MUL;
            end
            ST_V_MUL: begin
                cmd.mul_sel = MUL_VEL;
                state_next  = ST_V_RES;
            end
            ST_V_RES: begin
                cmd.vel_ld = 1'b1;
                state_next = ST_P_MUL;
            end
            ST_P_MUL: begin
                cmd.mul_sel = MUL_POS;
                state_next  = ST_P_RES;
            end
            ST_P_RES: begin
                cmd.pos_ld = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
        m_valid_next = cmd.commit ? 1'b1 : (m_valid_reg && !m_ready);
    end

    assign m_valid = m_valid_reg;
endmodule

[hw/rtl/tcc_datapath.sv]
// tap and delay memories, shared multiplier, accumulator and integrators
module tcc_datapath #(
    parameter int TAPS = tcc_pkg::TAPS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tcc_pkg::tcc_cmd_t             cmd,
    output tcc_pkg::tcc_status_t          status,
    input  logic [5:0]                    s_tap_index,
    input  logic signed [31:0]            s_tap_value,
    input  logic signed [31:0]            s_accel_sample,
    input  logic [31:0]                   s_sample_time,
    output logic signed [31:0]            m_position_out,
    output logic signed [31:0]            m_velocity_out,
    output logic [31:0]                   m_elapsed_time,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import tcc_pkg::*;

    localparam int AW    = $clog2(TAPS);
    localparam int ACC_W = 66 + AW;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    logic signed [31:0] gain_reg, offset_reg;
    logic [31:0]        start_reg;

    logic [AW-1:0] clr_cnt_reg, wi_reg, rd_ptr_reg, k_reg;
    logic          v1_reg, v2_reg;
    logic [31:0]   tap_rd, dly_rd;
    logic          tap_we, dly_we;
    logic [AW-1:0] dly_waddr;
    logic [31:0]   dly_wdata;

    logic signed [32:0]      mul_a, mul_b;
    logic signed [65:0]      mul_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic [31:0]        elapsed_reg, prev_time_reg, elapsed_in;
    logic signed [32:0] dt_reg;
    logic signed [31:0] filt_reg, scaled_reg, vel_reg, pos_reg;
    logic signed [31:0] prev_scaled_reg, prev_vel_reg, prev_pos_reg;
    logic signed [63:0] area;
    logic signed [32:0] pos_off;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= 32'sd65536;
            offset_reg <= '0;
            start_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SCALE_GAIN:  gain_reg   <= cfg_data;
                CFG_ZERO_OFFSET: offset_reg <= cfg_data;
                CFG_START_TIME:  start_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign tap_we    = cmd.accept_load && (32'(s_tap_index) < TAPS);
    assign dly_we    = cmd.clear_wr || cmd.accept_sample;
    assign dly_waddr = cmd.clear_wr ? clr_cnt_reg : wi_reg;
    assign dly_wdata = cmd.clear_wr ? 32'd0 : s_accel_sample;

    tcc_ram #(.WIDTH(32), .DEPTH(TAPS)) u_tap_ram (
        .aclk (aclk),
        .we   (tap_we),
        .waddr(AW'(s_tap_index)),
        .wdata(s_tap_value),
        .raddr(k_reg),
        .rdata(tap_rd)
    );

    tcc_ram #(.WIDTH(32), .DEPTH(TAPS)) u_dly_ram (
        .aclk (aclk),
        .we   (dly_we),
        .waddr(dly_waddr),
        .wdata(dly_wdata),
        .raddr(rd_ptr_reg),
        .rdata(dly_rd)
    );

    assign status.clr_last  = (clr_cnt_reg == LAST);
    assign status.mac_last  = (k_reg == LAST);
    assign status.pipe_busy = v1_reg || v2_reg;

    assign elapsed_in = s_sample_time - start_reg;

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_MAC: begin
                mul_a = 33'($signed(tap_rd));
                mul_b = 33'($signed(dly_rd));
            end
            MUL_SCALE: begin
                mul_a = 33'(filt_reg);
                mul_b = 33'(gain_reg);
            end
            MUL_VEL: begin
                mul_a = dt_reg;
                mul_b = 33'(scaled_reg) + 33'(prev_scaled_reg);
            end
            MUL_POS: begin
                mul_a = dt_reg;
                mul_b = 33'(vel_reg) + 33'(prev_vel_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign area    = 64'(mul_reg >>> INTEG_SHIFT);
    assign pos_off = 33'(pos_reg) + 33'(offset_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg     <= '0;
            wi_reg          <= LAST;
            rd_ptr_reg      <= '0;
            k_reg           <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            prev_time_reg   <= '0;
            prev_scaled_reg <= '0;
            prev_vel_reg    <= '0;
            prev_pos_reg    <= '0;
        end else begin
            if (cmd.clear_wr) begin
                clr_cnt_reg <= (clr_cnt_reg == LAST) ? '0 : clr_cnt_reg + 1'b1;
            end
            if (cmd.accept_sample) begin
                wi_reg     <= (wi_reg == '0) ? LAST : wi_reg - 1'b1;
                rd_ptr_reg <= wi_reg;
                k_reg      <= '0;
            end else if (cmd.mac_issue) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
                k_reg      <= (k_reg == LAST) ? '0 : k_reg + 1'b1;
            end
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
            if (cmd.commit) begin
                prev_time_reg   <= elapsed_reg;
                prev_scaled_reg <= scaled_reg;
                prev_vel_reg    <= vel_reg;
                prev_pos_reg    <= pos_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        if (cmd.accept_sample) begin
            acc_reg     <= '0;
            elapsed_reg <= elapsed_in;
            dt_reg      <= $signed({1'b0, elapsed_in}) - $signed({1'b0, prev_time_reg});
        end else if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(mul_reg);
        end
        if (cmd.filt_ld) begin
            filt_reg <= sat32(64'(acc_reg >>> FIR_FRAC_SHIFT));
        end
        if (cmd.scaled_ld) begin
            scaled_reg <= sat32(64'(mul_reg >>> SCALE_FRAC_SHIFT));
        end
        if (cmd.vel_ld) begin
            vel_reg <= (scaled_reg == '0 && prev_scaled_reg == '0) ? '0
                     : sat32(64'(prev_vel_reg) + area);
        end
        if (cmd.pos_ld) begin
            pos_reg <= (vel_reg == '0 && prev_vel_reg == '0) ? '0
                     : sat32(64'(prev_pos_reg) + area);
        end
        if (cmd.commit) begin
            m_position_out <= sat32(64'(pos_off));
            m_velocity_out <= vel_reg;
            m_elapsed_time <= elapsed_reg;
        end
    end
endmodule

[hw/rtl/translational_cue_channel.sv]
// top level of the translational cue channel: fir washout, gain, double integrator
//
//  channel | ports                                   | direction | carries
//  --------+-----------------------------------------+-----------+------------------------
//  s_      | s_valid s_ready s_action s_tap_* s_...   | in        | tap load or sample item
//  m_      | m_valid m_ready m_position_out ...       | out       | position, velocity, time
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data   | in        | register writes
//
// a load item leaves the input open; a sample item closes it while the single
// multiply-accumulate runs over the tap and delay memories, then gain and integrators
// after reset the delay memory is zeroed in one pass over all TAPS entries, s_ready low
// a finished result sits in the output register; the next item is taken meanwhile
// and the block stalls only when a second result is ready before the first is taken
module translational_cue_channel #(
    parameter int TAPS = tcc_pkg::TAPS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [5:0]                    s_tap_index,
    input  logic signed [31:0]            s_tap_value,
    input  logic signed [31:0]            s_accel_sample,
    input  logic [31:0]                   s_sample_time,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_position_out,
    output logic signed [31:0]            m_velocity_out,
    output logic [31:0]                   m_elapsed_time,
    // register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import tcc_pkg::*;

    // command and status between sequencer and datapath
    tcc_cmd_t    cmd;
    tcc_status_t status;

    // sequencer: clearing pass, item acceptance, step ordering, result handoff
    tcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_action(s_action),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: memories, shared multiplier, accumulator, integrator state
    tcc_datapath #(.TAPS(TAPS)) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_tap_index   (s_tap_index),
        .s_tap_value   (s_tap_value),
        .s_accel_sample(s_accel_sample),
        .s_sample_time (s_sample_time),
        .m_position_out(m_position_out),
        .m_velocity_out(m_velocity_out),
        .m_elapsed_time(m_elapsed_time),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );
endmodule

[hw/rtl/tcc_checker.sv]
// port-level checks for the translational cue channel, bound to the top level
module tcc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_action,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_position_out
);
    // a sample item keeps the input closed while it is worked on
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action |=> !s_ready)
        else $error("input still open after sample item");

    // a load item leaves the input open
    a_load_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_action |=> s_ready)
        else $error("input closed after load item");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a waiting result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position_out))
        else $error("waiting result changed");
endmodule

bind translational_cue_channel tcc_checker u_tcc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_action      (s_action),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_position_out(m_position_out)
);
